@@ sv/dot_matrix_center_generator_unit_defines.svh @@
// Assertion macros for the dot matrix center generator checker.
// Each macro expects a signal named clk, and all but DMCG_ASSERT_RST one named rst_n, where it is used.
`ifndef DOT_MATRIX_CENTER_GENERATOR_UNIT_DEFINES_SVH
`define DOT_MATRIX_CENTER_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMCG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmcg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DMCG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmcg assertion failed");

// Same-cycle implication that is also checked across reset.
`define DMCG_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("dmcg assertion failed");

`endif

@@ sv/dmcg_pkg.sv @@
// Shared types, constants and helper functions of the dot matrix center generator.
// No dependencies; every module in the other source files imports this package.
package dmcg_pkg;

  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
  localparam int DOT_IDX_W   = 6;
  localparam int LINE_W      = 4;
  localparam int CHAR_W      = 6;
  localparam int COORD_W     = 16;
  localparam int STEP_W      = 7;
  localparam int PITCH_W     = 10;
  localparam int BASE_W      = 11;
  localparam int COL_OFS_W   = 9;
  localparam int ROW_OFS_W   = 10;
  localparam int SIZE_W      = 6;
  localparam int OFFSET_W    = 10;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;

  localparam int DEF_MAX_CHARS   = 64;
  localparam int DEF_MAX_LINES   = 16;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic [2:0] REG_DOT_SIZE     = 3'd0;
  localparam logic [2:0] REG_DOT_SPACING  = 3'd1;
  localparam logic [2:0] REG_CHAR_SPACING = 3'd2;
  localparam logic [2:0] REG_LINE_SPACING = 3'd3;
  localparam logic [2:0] REG_OFFSET_X     = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y     = 3'd5;

  typedef struct packed {
    logic [GLYPH_BITS-1:0] glyph_bits;
    logic                  begin_text;
    logic                  begin_line;
  } dmcg_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [2:0]         dot_row;
    logic [2:0]         dot_col;
    logic               last_dot;
  } dmcg_out_t;

  typedef struct packed {
    logic [GLYPH_BITS-1:0] glyph_bits;
    logic [LINE_W-1:0]     line_idx;
    logic [CHAR_W-1:0]     char_idx;
  } dmcg_entry_t;

  typedef struct packed {
    logic [PITCH_W-1:0]                      pitch_x;
    logic [PITCH_W-1:0]                      pitch_y;
    logic [BASE_W-1:0]                       base_x;
    logic [BASE_W-1:0]                       base_y;
    logic [GLYPH_COLS-1:0][COL_OFS_W-1:0]    col_ofs;
    logic [GLYPH_ROWS-1:0][ROW_OFS_W-1:0]    row_ofs;
  } dmcg_geom_t;

  // Row of a dot from its bit index; exact for indices 0 to 34.
  function automatic logic [2:0] dot_row_of(input logic [DOT_IDX_W-1:0] idx);
    logic [10:0] prod;
    prod = 11'(idx) * 11'd13;
    return prod[8:6];
  endfunction

  function automatic logic [2:0] dot_col_of(input logic [DOT_IDX_W-1:0] idx);
    logic [2:0]           row;
    logic [DOT_IDX_W-1:0] base;
    row  = dot_row_of(idx);
    base = DOT_IDX_W'(row) * DOT_IDX_W'(GLYPH_COLS);
    return 3'(idx - base);
  endfunction

endpackage

@@ sv/dmcg_regs.sv @@
// Configuration registers on the APB-style port and the derived glyph geometry.
// Depends on dmcg_pkg.
module dmcg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [dmcg_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [dmcg_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [dmcg_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output dmcg_pkg::dmcg_geom_t             geom
);
  import dmcg_pkg::*;

  logic [SIZE_W-1:0]   dot_size_r, dot_spacing_r, char_spacing_r, line_spacing_r;
  logic [OFFSET_W-1:0] offset_x_r, offset_y_r;
  logic [2:0]          reg_idx;
  logic                wr_en;
  logic [SIZE_W-1:0]   dsz;
  logic [STEP_W-1:0]   step;
  dmcg_geom_t          geom_nxt;
  dmcg_geom_t          geom_r;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[APB_ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_size_r     <= SIZE_W'(1);
      dot_spacing_r  <= '0;
      char_spacing_r <= '0;
      line_spacing_r <= '0;
      offset_x_r     <= '0;
      offset_y_r     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DOT_SIZE:     dot_size_r     <= cfg_pwdata[SIZE_W-1:0];
        REG_DOT_SPACING:  dot_spacing_r  <= cfg_pwdata[SIZE_W-1:0];
        REG_CHAR_SPACING: char_spacing_r <= cfg_pwdata[SIZE_W-1:0];
        REG_LINE_SPACING: line_spacing_r <= cfg_pwdata[SIZE_W-1:0];
        REG_OFFSET_X:     offset_x_r     <= cfg_pwdata[OFFSET_W-1:0];
        REG_OFFSET_Y:     offset_y_r     <= cfg_pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DOT_SIZE:     cfg_prdata = APB_DATA_W'(dot_size_r);
      REG_DOT_SPACING:  cfg_prdata = APB_DATA_W'(dot_spacing_r);
      REG_CHAR_SPACING: cfg_prdata = APB_DATA_W'(char_spacing_r);
      REG_LINE_SPACING: cfg_prdata = APB_DATA_W'(line_spacing_r);
      REG_OFFSET_X:     cfg_prdata = APB_DATA_W'(offset_x_r);
      REG_OFFSET_Y:     cfg_prdata = APB_DATA_W'(offset_y_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // A dot size of zero behaves as one pixel.
  assign dsz  = (dot_size_r == '0) ? SIZE_W'(1) : dot_size_r;
  assign step = STEP_W'(dsz) + STEP_W'(dot_spacing_r);

  always_comb begin
    geom_nxt.pitch_x = PITCH_W'(PITCH_W'(step) * PITCH_W'(GLYPH_COLS))
                     - PITCH_W'(dot_spacing_r) + PITCH_W'(char_spacing_r);
    geom_nxt.pitch_y = PITCH_W'(PITCH_W'(step) * PITCH_W'(GLYPH_ROWS))
                     - PITCH_W'(dot_spacing_r) + PITCH_W'(line_spacing_r);
    geom_nxt.base_x  = BASE_W'(offset_x_r) + BASE_W'(dsz[SIZE_W-1:1]);
    geom_nxt.base_y  = BASE_W'(offset_y_r) + BASE_W'(dsz[SIZE_W-1:1]);
    for (int c = 0; c < GLYPH_COLS; c++) begin
      geom_nxt.col_ofs[c] = COL_OFS_W'(COL_OFS_W'(step) * COL_OFS_W'(c));
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      geom_nxt.row_ofs[r] = ROW_OFS_W'(ROW_OFS_W'(step) * ROW_OFS_W'(r));
    end
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

@@ sv/dmcg_front.sv @@
// Input side: accepts glyph beats, tracks line and character position, and
// pushes placed glyphs into the queue. Depends on dmcg_pkg.
module dmcg_front #(
  parameter int MAX_CHARS = dmcg_pkg::DEF_MAX_CHARS,
  parameter int MAX_LINES = dmcg_pkg::DEF_MAX_LINES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dmcg_pkg::dmcg_in_t    in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output dmcg_pkg::dmcg_entry_t q_entry
);
  import dmcg_pkg::*;

  logic [LINE_W-1:0] line_r, line_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic [LINE_W-1:0] place_line;
  logic [CHAR_W-1:0] place_char;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    place_line = line_r;
    place_char = char_r;
    if (in_data.begin_text) begin
      place_line = '0;
      place_char = '0;
    end else if (in_data.begin_line) begin
      if (line_r < LINE_W'(MAX_LINES - 1)) begin
        place_line = line_r + LINE_W'(1);
      end
      place_char = '0;
    end
    line_nxt = place_line;
    char_nxt = place_char;
    if (place_char < CHAR_W'(MAX_CHARS - 1)) begin
      char_nxt = place_char + CHAR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
      char_r <= '0;
    end else if (q_push) begin
      line_r <= line_nxt;
      char_r <= char_nxt;
    end
  end

  assign q_entry.glyph_bits = in_data.glyph_bits;
  assign q_entry.line_idx   = place_line;
  assign q_entry.char_idx   = place_char;

endmodule

@@ sv/dmcg_queue.sv @@
// Short first-in first-out queue of placed glyphs between front and back.
// Depends on dmcg_pkg.
module dmcg_queue #(
  parameter int DEPTH = dmcg_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dmcg_pkg::dmcg_entry_t push_entry,
  input  logic                  pop,
  output dmcg_pkg::dmcg_entry_t head,
  output logic                  empty,
  output logic                  full
);
  import dmcg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dmcg_entry_t      slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/dmcg_back.sv @@
// Output side: takes placed glyphs from the queue and emits one dot center per
// beat through an output register. Depends on dmcg_pkg.
module dmcg_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dmcg_pkg::dmcg_geom_t  geom,
  input  dmcg_pkg::dmcg_entry_t head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dmcg_pkg::dmcg_out_t   out_data
);
  import dmcg_pkg::*;

  logic [GLYPH_BITS-1:0] mask_r, mask_rest;
  logic [COORD_W-1:0]    x0_r, y0_r, x0_nxt, y0_nxt;
  logic                  out_valid_r;
  dmcg_out_t             out_r, out_nxt;
  logic                  busy, advance, emit, is_last;
  logic [DOT_IDX_W-1:0]  dot_idx;
  logic [2:0]            row, col;

  assign busy    = (mask_r != '0);
  assign advance = ~out_valid_r | ~out_stall;
  assign emit    = busy & advance;

  assign mask_rest = mask_r & (mask_r - GLYPH_BITS'(1));
  assign is_last   = (mask_rest == '0);
  assign q_pop     = ~q_empty & (~busy | (emit & is_last));

  always_comb begin
    dot_idx = '0;
    for (int i = GLYPH_BITS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        dot_idx = DOT_IDX_W'(i);
      end
    end
  end

  assign row = dot_row_of(dot_idx);
  assign col = dot_col_of(dot_idx);

  assign x0_nxt = COORD_W'(COORD_W'(head.char_idx) * COORD_W'(geom.pitch_x))
                + COORD_W'(geom.base_x);
  assign y0_nxt = COORD_W'(COORD_W'(head.line_idx) * COORD_W'(geom.pitch_y))
                + COORD_W'(geom.base_y);

  always_comb begin
    out_nxt.center_x = x0_r + COORD_W'(geom.col_ofs[col]);
    out_nxt.center_y = y0_r + COORD_W'(geom.row_ofs[row]);
    out_nxt.dot_row  = row;
    out_nxt.dot_col  = col;
    out_nxt.last_dot = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (q_pop) begin
      mask_r <= head.glyph_bits;
    end else if (emit) begin
      mask_r <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x0_r <= x0_nxt;
      y0_r <= y0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ sv/dot_matrix_center_generator_unit.sv @@
// Top level of the dot matrix center generator: registers, front, queue, back.
// Depends on dmcg_pkg, dmcg_regs, dmcg_front, dmcg_queue and dmcg_back.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   dmcg_in_t (glyph, begin flags)
//   out_     output     out_valid/out_stall dmcg_out_t (one dot center per beat)
//   cfg_     input      APB-style access    six geometry registers
//
// A glyph yields one dot center beat per set dot and an empty glyph none, paced by the
// single-beat output register; the next glyph is taken as the last dot is emitted.
// An accepted glyph passes the queue slot, the back end mask and origin registers and the
// output register. Reset clears the position counters, the queue and out_valid; the
// configuration registers reset. Output stalls fill the queue and then raise in_stall.
module dot_matrix_center_generator_unit #(
  parameter int MAX_CHARS   = dmcg_pkg::DEF_MAX_CHARS,
  parameter int MAX_LINES   = dmcg_pkg::DEF_MAX_LINES,
  parameter int QUEUE_DEPTH = dmcg_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dmcg_pkg::dmcg_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dmcg_pkg::dmcg_out_t             out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dmcg_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [dmcg_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [dmcg_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import dmcg_pkg::*;

  dmcg_geom_t  geom;
  dmcg_entry_t push_entry, head;
  logic        q_push, q_pop, q_empty, q_full;

  dmcg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .geom        (geom)
  );

  dmcg_front #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_LINES (MAX_LINES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  dmcg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  dmcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ sv/dmcg_checker.sv @@
// Port-level checks of the dot matrix center generator, bound to its top level.
// Depends on dmcg_pkg and dot_matrix_center_generator_unit_defines.svh.
`include "dot_matrix_center_generator_unit_defines.svh"

module dmcg_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input dmcg_pkg::dmcg_out_t out_data
);
  import dmcg_pkg::*;

  `DMCG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `DMCG_ASSERT_RST(a_reset_clear, $past(!rst_n), !out_valid && !in_stall)
  `DMCG_ASSERT_IMP(a_dot_range, out_valid, out_data.dot_row <= 3'd6 && out_data.dot_col <= 3'd4)
  `DMCG_ASSERT_NXT(a_glyph_unbroken, out_valid && !out_stall && !out_data.last_dot, out_valid)

endmodule

bind dot_matrix_center_generator_unit dmcg_checker u_dmcg_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for dot_matrix_center_generator_unit: random glyph beats in,
// dot center beats out, geometry registers over the APB-style port, with idle gaps and stalls.
// Depends on dmcg_pkg and the RTL of the block only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dmcg_pkg::*;

  localparam int CHAR_LIMIT    = DEF_MAX_CHARS;
  localparam int LINE_LIMIT    = DEF_MAX_LINES;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int ITEM_GOAL     = 110;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  dmcg_in_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  dmcg_out_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr   = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata  = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  dmcg_in_t  glyph_q[$];
  dmcg_out_t centers_due[$];
  logic      in_took    = 1'b0;
  int        in_gap     = 0;
  int        stall_left = 0;
  bit        calm       = 1'b0;
  int        errors     = 0;
  int        cycle_count = 0;
  int        queued     = 0;

  int geo_dot_size = 1;
  int geo_dot_gap  = 0;
  int geo_char_gap = 0;
  int geo_line_gap = 0;
  int geo_origin_x = 0;
  int geo_origin_y = 0;
  int line_pos     = 0;
  int char_pos     = 0;

  dot_matrix_center_generator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[dot_matrix_center_generator_unit] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  // Places one glyph at the current text position and queues its dot centers.
  task automatic place_glyph(input dmcg_in_t item);
    int dsz, step, cell_w, cell_h, half, x0, y0, total, n, row, col;
    dmcg_out_t c;
    if (item.begin_text) begin
      line_pos = 0;
      char_pos = 0;
    end else if (item.begin_line) begin
      if (line_pos < LINE_LIMIT - 1) line_pos++;
      char_pos = 0;
    end
    dsz    = (geo_dot_size == 0) ? 1 : geo_dot_size;
    step   = dsz + geo_dot_gap;
    cell_w = GLYPH_COLS * step - geo_dot_gap;
    cell_h = GLYPH_ROWS * step - geo_dot_gap;
    half   = dsz / 2;
    x0     = geo_origin_x + char_pos * (cell_w + geo_char_gap);
    y0     = geo_origin_y + line_pos * (cell_h + geo_line_gap);
    total  = $countones(item.glyph_bits);
    n      = 0;
    for (row = 0; row < GLYPH_ROWS; row++) begin
      for (col = 0; col < GLYPH_COLS; col++) begin
        if (item.glyph_bits[row * GLYPH_COLS + col]) begin
          n++;
          c.center_x = COORD_W'(x0 + col * step + half);
          c.center_y = COORD_W'(y0 + row * step + half);
          c.dot_row  = 3'(row);
          c.dot_col  = 3'(col);
          c.last_dot = (n == total);
          centers_due.insert(centers_due.size(), c);
        end
      end
    end
    if (char_pos < CHAR_LIMIT - 1) char_pos++;
  endtask

  always @(posedge clk) begin : watch
    dmcg_out_t want;
    in_took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) place_glyph(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (centers_due.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = centers_due.pop_front();
        if (out_data.center_x !== want.center_x)
          report_mismatch($sformatf("center_x got %0d want %0d", out_data.center_x,
                                    want.center_x));
        if (out_data.center_y !== want.center_y)
          report_mismatch($sformatf("center_y got %0d want %0d", out_data.center_y,
                                    want.center_y));
        if (out_data.dot_row !== want.dot_row)
          report_mismatch($sformatf("dot_row got %0d want %0d", out_data.dot_row,
                                    want.dot_row));
        if (out_data.dot_col !== want.dot_col)
          report_mismatch($sformatf("dot_col got %0d want %0d", out_data.dot_col,
                                    want.dot_col));
        if (out_data.last_dot !== want.last_dot)
          report_mismatch($sformatf("last_dot got %0b want %0b", out_data.last_dot,
                                    want.last_dot));
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (glyph_q.size() != 0) begin
        in_data  <= glyph_q.pop_front();
        in_valid <= 1'b1;
        in_gap   <= calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_DOT_SIZE:     geo_dot_size = value[SIZE_W-1:0];
      REG_DOT_SPACING:  geo_dot_gap  = value[SIZE_W-1:0];
      REG_CHAR_SPACING: geo_char_gap = value[SIZE_W-1:0];
      REG_LINE_SPACING: geo_line_gap = value[SIZE_W-1:0];
      REG_OFFSET_X:     geo_origin_x = value[OFFSET_W-1:0];
      REG_OFFSET_Y:     geo_origin_y = value[OFFSET_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] with_junk(input int width, input int v);
    return (($urandom_range(0, 1) != 0) ? ($urandom << width) : 32'd0) | 32'(v);
  endfunction

  task automatic program_geometry(input int dsz, input int dsp, input int csp,
                                  input int lsp, input int ox, input int oy);
    write_reg(REG_DOT_SIZE, with_junk(SIZE_W, dsz));
    write_reg(REG_DOT_SPACING, with_junk(SIZE_W, dsp));
    write_reg(REG_CHAR_SPACING, with_junk(SIZE_W, csp));
    write_reg(REG_LINE_SPACING, with_junk(SIZE_W, lsp));
    write_reg(REG_OFFSET_X, with_junk(OFFSET_W, ox));
    write_reg(REG_OFFSET_Y, with_junk(OFFSET_W, oy));
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  function automatic int rand_reg(input int width);
    case ($urandom_range(0, 4))
      0: return 0;
      1: return (1 << width) - 1;
      default: return $urandom_range(0, (1 << width) - 1);
    endcase
  endfunction

  function automatic logic [GLYPH_BITS-1:0] make_glyph();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return GLYPH_BITS'(1) << $urandom_range(0, GLYPH_BITS - 1);
      default: return r[GLYPH_BITS-1:0];
    endcase
  endfunction

  task automatic add_glyph(input bit text_start, input bit line_start,
                           input logic [GLYPH_BITS-1:0] bits);
    dmcg_in_t item;
    item.glyph_bits = bits;
    item.begin_text = text_start;
    item.begin_line = line_start;
    glyph_q.insert(glyph_q.size(), item);
    queued++;
  endtask

  task automatic load_directed();
    add_glyph(1'b1, 1'b0, '1);
    add_glyph(1'b0, 1'b0, '0);
    add_glyph(1'b0, 1'b0, GLYPH_BITS'(1));
    add_glyph(1'b0, 1'b0, GLYPH_BITS'(1) << (GLYPH_BITS - 1));
    add_glyph(1'b0, 1'b1, GLYPH_BITS'(1) << (GLYPH_COLS - 1));
    add_glyph(1'b1, 1'b1, GLYPH_BITS'(1) << ((GLYPH_ROWS - 1) * GLYPH_COLS));
    add_glyph(1'b0, 1'b1, GLYPH_BITS'(35'h5_5555_5555));
    add_glyph(1'b0, 1'b0, GLYPH_BITS'(35'h2_AAAA_AAAA));
    add_glyph(1'b0, 1'b1, '0);
  endtask

  // A text is usually opened with begin_text; some are not, and some beats carry noise flags.
  task automatic add_text();
    int len;
    len = $urandom_range(2, 12);
    add_glyph($urandom_range(0, 9) != 0, 1'b0, make_glyph());
    repeat (len) begin
      if ($urandom_range(0, 9) == 0)
        add_glyph($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0, make_glyph());
      else
        add_glyph(1'b0, $urandom_range(0, 3) == 0, make_glyph());
    end
  endtask

  task automatic settle();
    do @(negedge clk); while (glyph_q.size() != 0 || in_valid || centers_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_directed();
    settle();
    program_geometry(63, 63, 63, 63, 1023, 1023);
    load_directed();
    settle();

    program_geometry(0, 0, 0, 0, 0, 0);
    add_glyph(1'b1, 1'b0, make_glyph());
    repeat (LINE_LIMIT + 2) add_glyph(1'b0, 1'b1, make_glyph());
    repeat (2) add_glyph(1'b0, 1'b0, make_glyph());
    settle();

    program_geometry(63, 63, 63, 63, 1023, 1023);
    add_glyph(1'b1, 1'b0, make_glyph());
    repeat (CHAR_LIMIT + 2)
      add_glyph(1'b0, 1'b0, ($urandom_range(0, 3) == 0) ? make_glyph() : GLYPH_BITS'(0));
    add_glyph(1'b0, 1'b0, '1);
    add_glyph(1'b0, 1'b1, '1);
    settle();

    while (queued < ITEM_GOAL) begin
      program_geometry(rand_reg(SIZE_W), rand_reg(SIZE_W), rand_reg(SIZE_W),
                       rand_reg(SIZE_W), rand_reg(OFFSET_W), rand_reg(OFFSET_W));
      add_text();
      settle();
    end

    if (errors == 0) begin
      $display("[dot_matrix_center_generator_unit] OK");
    end else begin
      $display("[dot_matrix_center_generator_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/dmcg_pkg.sv
sv/dmcg_regs.sv
sv/dmcg_front.sv
sv/dmcg_queue.sv
sv/dmcg_back.sv
sv/dot_matrix_center_generator_unit.sv
sv/dmcg_checker.sv
verif/tb_top.sv
